/* rtl/core/isa_pkg.sv */
package isa_pkg;

  localparam int DEPTH       = 32;
  localparam int MAX_RESULTS = 32;

  localparam int OPCODE_W = 3;
  localparam int POS_W    = 5;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [OPCODE_W-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_ERASE  = 3'd2,
    OP_POP    = 3'd3,
    OP_CLEAR  = 3'd4,
    OP_DUMP   = 3'd5
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

  typedef struct packed {
    logic [OPCODE_W-1:0]      opcode;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] data_word;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [WORD_W-1:0] element_value;
    logic [COUNT_W-1:0]       element_count;
    logic                     last_result;
  } out_item_t;

  typedef struct packed {
    logic exec;
    logic dump_begin;
    logic dump_step;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic empty;
    logic dump_last;
  } stat_t;

endpackage

/* rtl/core/isa_ifs.sv */
interface isa_in_if;
  import isa_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface isa_out_if;
  import isa_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* rtl/core/isa_ctrl.sv */
module isa_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic [isa_pkg::OPCODE_W-1:0]     in_opcode,
  output logic                             in_ready,
  input  isa_pkg::stat_t                   stat,
  output isa_pkg::cmd_t                    cmd
);
  import isa_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = stat.out_free;
        if (in_valid && stat.out_free) begin
          cmd.exec = 1'b1;
          if (in_opcode == OP_DUMP && !stat.empty) begin
            cmd.dump_begin = 1'b1;
            state_nxt      = S_DUMP;
          end
        end
      end
      S_DUMP: begin
        if (stat.out_free) begin
          cmd.dump_step = 1'b1;
          if (stat.dump_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/isa_dpath.sv */
module isa_dpath (
  input  logic               clk,
  input  logic               rst_n,
  input  isa_pkg::in_item_t  in_item,
  input  isa_pkg::cmd_t      cmd,
  output isa_pkg::stat_t     stat,
  input  logic               out_ready,
  output logic               out_valid,
  output isa_pkg::out_item_t out_item
);
  import isa_pkg::*;

  logic signed [WORD_W-1:0] cells_r   [DEPTH];
  logic signed [WORD_W-1:0] cells_nxt [DEPTH];
  logic signed [WORD_W-1:0] up_w      [DEPTH];
  logic signed [WORD_W-1:0] down_w    [DEPTH];

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [IDX_W-1:0] dump_idx_r;
  logic [IDX_W-1:0] dump_idx_nxt;
  logic [CNT_W-1:0] dump_cnt;

  logic      out_valid_r;
  logic      out_valid_nxt;
  out_item_t out_item_r;
  out_item_t out_item_nxt;

  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] count_ext;
  logic             bad_index;
  logic             full;
  logic             do_app;
  logic             do_ins;
  logic             do_ers;
  status_t          st;

  // neighbor taps of each cell
  for (genvar i = 0; i < DEPTH; i++) begin : g_tap
    if (i == 0) begin : g_first
      assign up_w[i] = cells_r[i];
    end else begin : g_mid_up
      assign up_w[i] = cells_r[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign down_w[i] = cells_r[i];
    end else begin : g_mid_down
      assign down_w[i] = cells_r[i+1];
    end
  end

  assign pos_ext   = CMP_W'(in_item.position);
  assign count_ext = CMP_W'(count_r);
  assign bad_index = (pos_ext >= count_ext);
  assign full      = (count_r == CNT_W'(DEPTH));
  assign dump_cnt  = CNT_W'(dump_idx_r) + 1'b1;

  always_comb begin
    st        = ST_OK;
    count_nxt = count_r;
    do_app    = 1'b0;
    do_ins    = 1'b0;
    do_ers    = 1'b0;
    unique case (in_item.opcode)
      OP_APPEND: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          do_app    = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      OP_INSERT: begin
        if (bad_index) begin
          st = ST_BAD_INDEX;
        end else if (full) begin
          st = ST_FULL;
        end else begin
          do_ins    = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      OP_ERASE: begin
        if (bad_index) begin
          st = ST_BAD_INDEX;
        end else begin
          do_ers    = 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
      OP_POP: begin
        if (count_r == '0) begin
          st = ST_EMPTY;
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
      OP_CLEAR: begin
        count_nxt = '0;
      end
      OP_DUMP: begin
        st = ST_EMPTY;
      end
      default: begin
        st = ST_OK;
      end
    endcase
    if (!cmd.exec) begin
      count_nxt = count_r;
      do_app    = 1'b0;
      do_ins    = 1'b0;
      do_ers    = 1'b0;
    end
  end

  // every cell decides its own next value, all shift together in the same cycle
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cells_nxt[i] = cells_r[i];
      if (do_app && CMP_W'(i) == count_ext) begin
        cells_nxt[i] = in_item.data_word;
      end
      if (do_ins) begin
        if (CMP_W'(i) == pos_ext) begin
          cells_nxt[i] = in_item.data_word;
        end else if (CMP_W'(i) > pos_ext) begin
          cells_nxt[i] = up_w[i];
        end
      end
      if (do_ers && CMP_W'(i) >= pos_ext) begin
        cells_nxt[i] = down_w[i];
      end
    end
  end

  assign stat.out_free  = !out_valid_r || out_ready;
  assign stat.empty     = (count_r == '0);
  assign stat.dump_last = (dump_cnt == count_r) ||
                          ((DEPTH > MAX_RESULTS) && (dump_cnt == CNT_W'(MAX_RESULTS)));

  always_comb begin
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && !out_ready;
    dump_idx_nxt  = dump_idx_r;
    if (cmd.dump_begin) begin
      dump_idx_nxt = '0;
    end else if (cmd.exec) begin
      out_valid_nxt              = 1'b1;
      out_item_nxt.status        = st;
      out_item_nxt.element_value = '0;
      out_item_nxt.element_count = COUNT_W'(count_nxt);
      out_item_nxt.last_result   = 1'b1;
    end else if (cmd.dump_step) begin
      out_valid_nxt              = 1'b1;
      out_item_nxt.status        = ST_OK;
      out_item_nxt.element_value = cells_r[dump_idx_r];
      out_item_nxt.element_count = COUNT_W'(count_r);
      out_item_nxt.last_result   = stat.dump_last;
      dump_idx_nxt               = dump_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
      dump_idx_r  <= '0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      dump_idx_r  <= dump_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cells_r    <= cells_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* rtl/core/indexed_shift_array_core.sv */
// Ordered list of up to DEPTH signed 32-bit words held in register cells.
// Input channel in_ch: opcode (append, insert, erase, pop, clear, dump),
// position and data_word, taken when valid and ready are both high.
// Result channel out_ch: status, element_value, element_count, last_result.
// Every request but a dump of a non-empty list gives one result, registered
// and shown in the cycle after the request is accepted; insert and erase shift
// all cells as the result is registered, so such requests sustain one per
// cycle while the receiver takes each result. A dump of N words resets the
// read index, then gives one word per cycle while the receiver keeps up (N
// capped at MAX_RESULTS); in_ch ready is low while the dump walks the index.
// The output register is the only buffer: when the receiver stalls, the
// result holds and ready drops until it is taken, after which a new request
// may be accepted in the same cycle that frees the register.
// Synchronous reset empties the list (count zero) and clears the result
// valid; stored words keep whatever they held and are never read before
// being written again.
module indexed_shift_array_core (
  input  logic      clk,
  input  logic      rst_n,
  isa_in_if.sink    in_ch,
  isa_out_if.source out_ch
);
  import isa_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  isa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_opcode (in_ch.payload.opcode),
    .in_ready  (in_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  isa_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_ch.payload),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_item  (out_ch.payload)
  );

  a_step_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.dump_step |-> !cmd.exec && !stat.empty)
    else $error("dump step overlaps a request or reads an empty list");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.payload.status != ST_OK |-> out_ch.payload.last_result)
    else $error("error status on a result that is not last");

  a_single_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.payload.opcode != OP_DUMP |=>
      out_ch.valid && out_ch.payload.last_result)
    else $error("missing result after single-result request");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> 32'(out_ch.payload.element_count) <= 32'(DEPTH))
    else $error("element count beyond depth");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import isa_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;
  localparam logic [WORD_W-1:0]   WORD_MAX    = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0]   WORD_MIN    = 32'h8000_0000;
  localparam logic [WORD_W-1:0]   WORD_ONES   = 32'hffff_ffff;
  localparam int RANDOM_ITEMS = 350;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT = 400000;

  class shift_array_model;
    logic signed [WORD_W-1:0] words[DEPTH];
    int word_count;
    int mismatches;
    out_item_t awaited[$];

    function new();
      word_count = 0;
      mismatches = 0;
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction

    function void push_result(status_t st, logic signed [WORD_W-1:0] value, bit last);
      out_item_t res;
      res.status = st;
      res.element_value = value;
      res.element_count = word_count[COUNT_W-1:0];
      res.last_result = last;
      awaited = {awaited, res};
    endfunction

    function void note_request(in_item_t req);
      status_t st;
      int pos;
      int n;
      int i;
      st = ST_OK;
      pos = int'(req.position);
      case (req.opcode)
        OP_APPEND: begin
          if (word_count >= DEPTH) st = ST_FULL;
          else begin
            words[word_count] = req.data_word;
            word_count++;
          end
        end
        OP_INSERT: begin
          if (pos >= word_count) st = ST_BAD_INDEX;
          else if (word_count >= DEPTH) st = ST_FULL;
          else begin
            for (i = word_count; i > pos; i--) words[i] = words[i-1];
            words[pos] = req.data_word;
            word_count++;
          end
        end
        OP_ERASE: begin
          if (pos >= word_count) st = ST_BAD_INDEX;
          else begin
            for (i = pos; i + 1 < word_count; i++) words[i] = words[i+1];
            word_count--;
          end
        end
        OP_POP: begin
          if (word_count == 0) st = ST_EMPTY;
          else word_count--;
        end
        OP_CLEAR: word_count = 0;
        OP_DUMP: begin
          if (word_count == 0) st = ST_EMPTY;
          else begin
            n = (word_count > MAX_RESULTS) ? MAX_RESULTS : word_count;
            for (i = 0; i < n; i++) push_result(ST_OK, words[i], i + 1 == n);
            return;
          end
        end
        default: ;
      endcase
      push_result(st, '0, 1'b1);
    endfunction

    function void compare_field(string field, logic signed [WORD_W:0] want,
                                logic signed [WORD_W:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d value %0d",
                 $time, got.status, got.element_value);
        $display("%0t: unexpected result, actual count %0d last %0b",
                 $time, got.element_count, got.last_result);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("element_value", want.element_value, got.element_value);
      compare_field("element_count", want.element_count, got.element_count);
      compare_field("last_result", want.last_result, got.last_result);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit long_hold_req;
  shift_array_model sb;

  isa_in_if  in_if();
  isa_out_if out_if();

  indexed_shift_array_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  function automatic in_item_t mk(logic [OPCODE_W-1:0] op, logic [POS_W-1:0] pos,
                                  logic [WORD_W-1:0] data);
    in_item_t req;
    req.opcode = op;
    req.position = pos;
    req.data_word = data;
    return req;
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return WORD_ONES;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t pick_request(bit growing);
    int r;
    int n;
    logic [POS_W-1:0] pos;
    r = $urandom_range(0, 99);
    n = sb.word_count;
    pos = (n > 0) ? POS_W'($urandom_range(0, n - 1)) : '0;
    if (r < 3) begin
      return mk($urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI, POS_W'($urandom),
                $urandom);
    end
    if (r < 4) return mk(OP_CLEAR, POS_W'($urandom), $urandom);
    if (r < 11) return mk(OP_DUMP, POS_W'($urandom), $urandom);
    if (r < 15) begin
      return mk(OPCODE_W'($urandom_range(0, 7)), POS_W'($urandom_range(0, 31)), $urandom);
    end
    if (growing ? r < 70 : r < 35) begin
      if (n > 0 && $urandom_range(0, 1)) return mk(OP_INSERT, pos, rand_word());
      return mk(OP_APPEND, POS_W'($urandom), rand_word());
    end
    if ($urandom_range(0, 3) == 0) return mk(OP_POP, POS_W'($urandom), $urandom);
    return mk(OP_ERASE, pos, $urandom);
  endfunction

  task automatic send_item(input in_item_t req);
    in_if.valid <= 1'b1;
    in_if.payload <= req;
    do @(posedge clk); while (!in_if.ready);
    sb.note_request(req);
  endtask

  task automatic idle_gap(input int n);
    if (n == 0) return;
    in_if.valid <= 1'b0;
    in_if.payload <= mk(OPCODE_W'($urandom_range(0, 7)), POS_W'($urandom_range(0, 31)),
                        $urandom);
    repeat (n) @(posedge clk);
  endtask

  // wait until every expected result has come back, then a little longer
  task automatic settle();
    in_if.valid <= 1'b0;
    do @(negedge clk); while (sb.outstanding() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) sb.check_result(out_if.payload);
  end

  // receiver: stall pattern changes in random windows, long hold on request
  initial begin
    int mode;
    int span;
    int hold;
    hold = 0;
    out_if.ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 80);
      repeat (span) begin
        @(posedge clk);
        if (long_hold_req) begin
          long_hold_req = 1'b0;
          hold = HOLD_CYCLES;
        end
        if (hold > 0) begin
          hold--;
          out_if.ready <= 1'b0;
        end else begin
          case (mode)
            0: out_if.ready <= 1'b1;
            1: out_if.ready <= ($urandom_range(0, 9) >= 3);
            2: out_if.ready <= ($urandom_range(0, 3) == 0);
            default: out_if.ready <= ~out_if.ready;
          endcase
        end
      end
    end
  end

  initial begin
    int sent;
    int burst;
    int i;
    bit growing;
    bit held;
    bit paused;
    sb = new();
    long_hold_req = 1'b0;
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.payload <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // empty list corner cases, then edits, dumps and spare opcodes on a short list
    send_item(mk(OP_POP, '0, '0));
    send_item(mk(OP_DUMP, '1, '1));
    send_item(mk(OP_ERASE, '0, '0));
    send_item(mk(OP_INSERT, '0, WORD_ONES));
    send_item(mk(OP_APPEND, '0, WORD_MAX));
    send_item(mk(OP_APPEND, '1, WORD_MIN));
    idle_gap(3);
    send_item(mk(OP_APPEND, '0, WORD_ONES));
    send_item(mk(OP_APPEND, '0, '0));
    send_item(mk(OP_INSERT, 5'd0, 32'h5555_5555));
    send_item(mk(OP_INSERT, 5'd4, 32'haaaa_aaaa));
    send_item(mk(OP_INSERT, 5'd6, 32'h1234_5678));
    send_item(mk(OP_INSERT, '1, 32'h0bad_0bad));
    send_item(mk(OP_ERASE, 5'd0, '0));
    send_item(mk(OP_ERASE, 5'd4, '1));
    send_item(mk(OP_ERASE, 5'd5, '0));
    send_item(mk(OP_DUMP, '0, '0));
    send_item(mk(OP_SPARE_LO, '1, '1));
    send_item(mk(OP_SPARE_HI, '0, '0));
    send_item(mk(OP_POP, '0, '0));
    send_item(mk(OP_CLEAR, '0, '0));
    send_item(mk(OP_DUMP, '0, '0));
    // fill to the top; with a five-bit position an insert on a full list can only report full
    while (sb.word_count < DEPTH) send_item(mk(OP_APPEND, POS_W'($urandom), rand_word()));
    send_item(mk(OP_APPEND, '0, WORD_MAX));
    send_item(mk(OP_INSERT, '1, WORD_MIN));
    send_item(mk(OP_INSERT, '0, '0));
    send_item(mk(OP_DUMP, '0, '0));
    send_item(mk(OP_ERASE, '1, '0));
    send_item(mk(OP_DUMP, '0, '0));
    settle();

    sent = 0;
    growing = 1'b1;
    held = 1'b0;
    paused = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 12);
      if ($urandom_range(0, 9) == 0) growing = !growing;
      if (sb.word_count == 0) growing = 1'b1;
      else if (sb.word_count == DEPTH) growing = ($urandom_range(0, 3) == 0);
      if (sent >= 100 && !held) begin
        held = 1'b1;
        long_hold_req = 1'b1;
        burst = 16;
      end
      if (sent >= 220 && !paused) begin
        paused = 1'b1;
        settle();
      end
      for (i = 0; i < burst; i++) begin
        send_item(pick_request(growing));
        sent++;
      end
      if (sent >= 150 && sent < 190) idle_gap(0);
      else idle_gap($urandom_range(0, 1) ? 0 : $urandom_range(1, 8));
    end
    settle();

    if (sb.mismatches == 0 && sb.outstanding() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
